FILE: rtl/scc_pkg.sv
// Shared types and constants for the strongly connected component counter.
package scc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int EIDX_W       = $clog2(MAX_EDGES);
  localparam int PTR_W        = EIDX_W + 1;
  localparam int CNT_W        = VTX_W + 1;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [CNT_W-1:0] edge_source;
    logic [CNT_W-1:0] edge_target;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] nontrivial_components;
    logic [CNT_W-1:0] total_components;
    logic             edges_dropped;
  } out_item_t;

  typedef struct packed {
    logic [VTX_W-1:0] dest;
    logic [PTR_W-1:0] link;
  } edge_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [PTR_W-1:0] cursor;
  } frame_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_ENTER,
    ST_HEAD,
    ST_STEP,
    ST_EDGE,
    ST_CHECK,
    ST_POP_RD,
    ST_POP_CHK,
    ST_FRAME_RD,
    ST_FRAME_LD,
    ST_FRAME_LOW,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/strongly_connected_component_count_core.sv
// Tarjan strongly connected component counter over memory-held adjacency lists.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one transaction per
//   item. opcode OP_ADD appends a directed edge to the source vertex's list
//   (no result). opcode OP_RUN runs Tarjan's search over vertices
//   1..vertex_count (capped at 1024) and returns exactly one result transaction.
//   A run scans each vertex, walks the stored edges of every vertex entered
//   (a target past the count is skipped), pops and closes each component,
//   then sweeps to clear visit stamps and on-stack marks; every step
//   waits on the registered reads of the state memories. in_stall is high
//   while any item is being worked on.
//   Output channel (out_valid / out_stall / out_data) is a single register;
//   a finished run holds in ST_DONE while an older result is still stalled.
//   cfg_we / cfg_wdata write vertex_count (write only when idle).
//   Reset (rst, synchronous) starts a sweep clearing list heads,
//   visit stamps and on-stack marks; in_stall stays high for its length.
//   Edge count and the dropped-edge flag clear at reset only.
module strongly_connected_component_count_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  scc_pkg::in_item_t       in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output scc_pkg::out_item_t      out_data,
  input  logic                    cfg_we,
  input  logic [scc_pkg::CNT_W-1:0] cfg_wdata
);
  import scc_pkg::*;

  // ---------------- state memories ----------------
  logic [PTR_W-1:0] head_mem  [MAX_VERTICES];
  edge_t            edge_mem  [MAX_EDGES];
  logic [CNT_W-1:0] stamp_mem [MAX_VERTICES];
  logic [CNT_W-1:0] low_mem   [MAX_VERTICES];
  logic             on_mem    [MAX_VERTICES];
  logic [VTX_W-1:0] comp_mem  [MAX_VERTICES];
  frame_t           frame_mem [MAX_VERTICES];

  logic             head_we, stamp_we, low_we, on_we, comp_we, frame_we, edge_we;
  logic [VTX_W-1:0] head_waddr, head_raddr, stamp_waddr, stamp_raddr;
  logic [VTX_W-1:0] low_waddr, low_raddr, on_waddr, on_raddr;
  logic [VTX_W-1:0] comp_waddr, comp_raddr, frame_waddr, frame_raddr;
  logic [EIDX_W-1:0] edge_waddr, edge_raddr;
  logic [PTR_W-1:0] head_wdata, head_rd;
  logic [CNT_W-1:0] stamp_wdata, stamp_rd, low_wdata, low_rd;
  logic             on_wdata, on_rd;
  logic [VTX_W-1:0] comp_wdata, comp_rd;
  frame_t           frame_wdata, frame_rd;
  edge_t            edge_wdata, edge_rd;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_rd <= head_mem[head_raddr];
  end
  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rd <= edge_mem[edge_raddr];
  end
  always_ff @(posedge clk) begin
    if (stamp_we) stamp_mem[stamp_waddr] <= stamp_wdata;
    stamp_rd <= stamp_mem[stamp_raddr];
  end
  always_ff @(posedge clk) begin
    if (low_we) low_mem[low_waddr] <= low_wdata;
    low_rd <= low_mem[low_raddr];
  end
  always_ff @(posedge clk) begin
    if (on_we) on_mem[on_waddr] <= on_wdata;
    on_rd <= on_mem[on_raddr];
  end
  always_ff @(posedge clk) begin
    if (comp_we) comp_mem[comp_waddr] <= comp_wdata;
    comp_rd <= comp_mem[comp_raddr];
  end
  always_ff @(posedge clk) begin
    if (frame_we) frame_mem[frame_waddr] <= frame_wdata;
    frame_rd <= frame_mem[frame_raddr];
  end

  // ---------------- control registers ----------------
  state_t           state, state_next;
  logic [CNT_W-1:0] vertex_count;
  logic [PTR_W-1:0] edge_total;
  logic             overflow_mark;
  logic [VTX_W-1:0] sweep;
  logic [VTX_W-1:0] add_src, add_dst;
  logic [CNT_W-1:0] root;          // scan index r
  logic [CNT_W-1:0] clock_now;
  logic [CNT_W-1:0] comp_depth;
  logic [CNT_W-1:0] frame_depth;   // frames including the cached top
  logic [VTX_W-1:0] pend;          // vertex about to be entered
  logic [VTX_W-1:0] cur_v;         // top frame, cached in flops
  logic [PTR_W-1:0] cur_cursor;
  logic [CNT_W-1:0] cur_low, cur_stamp, child_low;
  logic [1:0]       pop_count;     // saturating pops for this component
  logic [CNT_W-1:0] big_cnt, total_cnt;

  // ---------------- helpers ----------------
  logic [CNT_W-1:0] nv, root_inc, src_m1, dst_m1, cdepth_m1, fdepth_m1, fdepth_m2;
  logic [PTR_W-1:0] cursor_m1, total_inc;
  logic             in_acc, add_bad, root_more, edge_out, out_load;

  assign nv        = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                           : vertex_count;
  assign root_inc  = root + CNT_W'(1);
  assign root_more = root_inc < nv;
  assign src_m1    = in_data.edge_source - CNT_W'(1);
  assign dst_m1    = in_data.edge_target - CNT_W'(1);
  assign cdepth_m1 = comp_depth - CNT_W'(1);
  assign fdepth_m1 = frame_depth - CNT_W'(1);
  assign fdepth_m2 = frame_depth - CNT_W'(2);
  assign cursor_m1 = cur_cursor - PTR_W'(1);
  assign total_inc = edge_total + PTR_W'(1);
  assign edge_out  = {1'b0, edge_rd.dest} >= nv;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign add_bad  = (in_data.edge_source == '0) || (in_data.edge_target == '0) ||
                    (in_data.edge_source > nv) || (in_data.edge_target > nv) ||
                    edge_total[EIDX_W];
  // result register takes a new transaction when empty or draining this cycle
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:      if (sweep == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.opcode == OP_RUN) begin
            state_next = (nv == '0) ? ST_CLEAR : ST_SCAN_RD;
          end else if (!add_bad) begin
            state_next = ST_ADD;
          end
        end
      end
      ST_ADD:       state_next = ST_IDLE;
      ST_SCAN_RD:   state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (stamp_rd == '0) state_next = ST_ENTER;
        else                state_next = root_more ? ST_SCAN_RD : ST_CLEAR;
      end
      ST_ENTER:     state_next = ST_HEAD;
      ST_HEAD:      state_next = ST_STEP;
      ST_STEP: begin
        if (cur_cursor != '0)          state_next = ST_EDGE;
        else if (cur_low == cur_stamp) state_next = ST_POP_RD;
        else                           state_next = ST_FRAME_RD;
      end
      ST_EDGE:      state_next = edge_out ? ST_STEP : ST_CHECK;
      ST_CHECK:     state_next = (stamp_rd == '0) ? ST_ENTER : ST_STEP;
      ST_POP_RD:    state_next = (comp_depth == '0) ? ST_FRAME_RD : ST_POP_CHK;
      ST_POP_CHK:   state_next = (comp_rd == cur_v) ? ST_FRAME_RD : ST_POP_RD;
      ST_FRAME_RD: begin
        if (frame_depth == CNT_W'(1)) state_next = root_more ? ST_SCAN_RD : ST_CLEAR;
        else                          state_next = ST_FRAME_LD;
      end
      ST_FRAME_LD:  state_next = ST_FRAME_LOW;
      ST_FRAME_LOW: state_next = ST_STEP;
      ST_CLEAR:     if (sweep == '1) state_next = ST_DONE;
      ST_DONE:      if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:      state_next = ST_INIT;
    endcase
  end

  // ---------------- memory port control ----------------
  always_comb begin
    head_we = 1'b0;  head_waddr = '0;  head_wdata = '0;  head_raddr = '0;
    edge_we = 1'b0;  edge_waddr = '0;  edge_wdata = '0;  edge_raddr = '0;
    stamp_we = 1'b0; stamp_waddr = '0; stamp_wdata = '0; stamp_raddr = '0;
    low_we = 1'b0;   low_waddr = '0;   low_wdata = '0;   low_raddr = '0;
    on_we = 1'b0;    on_waddr = '0;    on_wdata = 1'b0;  on_raddr = '0;
    comp_we = 1'b0;  comp_waddr = '0;  comp_wdata = '0;  comp_raddr = '0;
    frame_we = 1'b0; frame_waddr = '0; frame_wdata = '0; frame_raddr = '0;
    unique case (state)
      ST_INIT: begin
        head_we = 1'b1;  head_waddr = sweep;
        stamp_we = 1'b1; stamp_waddr = sweep;
        on_we = 1'b1;    on_waddr = sweep;
      end
      ST_CLEAR: begin
        stamp_we = 1'b1; stamp_waddr = sweep;
        on_we = 1'b1;    on_waddr = sweep;
      end
      ST_IDLE:    head_raddr = src_m1[VTX_W-1:0];
      ST_ADD: begin
        edge_we    = 1'b1;
        edge_waddr = edge_total[EIDX_W-1:0];
        edge_wdata = '{dest: add_dst, link: head_rd};
        head_we    = 1'b1;
        head_waddr = add_src;
        head_wdata = total_inc;
      end
      ST_SCAN_RD: stamp_raddr = root[VTX_W-1:0];
      ST_ENTER: begin
        stamp_we = 1'b1; stamp_waddr = pend; stamp_wdata = clock_now + CNT_W'(1);
        comp_we = 1'b1;  comp_waddr = comp_depth[VTX_W-1:0]; comp_wdata = pend;
        on_we = 1'b1;    on_waddr = pend; on_wdata = 1'b1;
        head_raddr = pend;
        if (frame_depth != '0) begin
          // spill the cached top frame and its low-link
          frame_we = 1'b1; frame_waddr = fdepth_m1[VTX_W-1:0];
          frame_wdata = '{vertex: cur_v, cursor: cur_cursor};
          low_we = 1'b1;   low_waddr = cur_v; low_wdata = cur_low;
        end
      end
      ST_STEP:    edge_raddr = cursor_m1[EIDX_W-1:0];
      ST_EDGE: begin
        stamp_raddr = edge_rd.dest;
        on_raddr    = edge_rd.dest;
      end
      ST_POP_RD:  comp_raddr = cdepth_m1[VTX_W-1:0];
      ST_POP_CHK: begin
        on_we = 1'b1; on_waddr = comp_rd; on_wdata = 1'b0;
      end
      ST_FRAME_RD: frame_raddr = fdepth_m2[VTX_W-1:0];
      ST_FRAME_LD: begin
        low_raddr   = frame_rd.vertex;
        stamp_raddr = frame_rd.vertex;
      end
      default: ;
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      vertex_count  <= CNT_W'(1);
      edge_total    <= '0;
      overflow_mark <= 1'b0;
      sweep         <= '0;
      out_valid     <= 1'b0;
      frame_depth   <= '0;
      comp_depth    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) vertex_count <= cfg_wdata;
      out_valid <= out_load || (out_valid && out_stall);

      unique case (state)
        ST_INIT, ST_CLEAR: sweep <= sweep + VTX_W'(1);
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.opcode == OP_RUN) begin
              root <= '0; clock_now <= '0; comp_depth <= '0; frame_depth <= '0;
              big_cnt <= '0; total_cnt <= '0; sweep <= '0;
            end else if (add_bad) begin
              overflow_mark <= 1'b1;
            end else begin
              add_src <= src_m1[VTX_W-1:0];
              add_dst <= dst_m1[VTX_W-1:0];
            end
          end
        end
        ST_ADD: edge_total <= total_inc;
        ST_SCAN_CHK: begin
          if (stamp_rd == '0) pend <= root[VTX_W-1:0];
          else                root <= root_inc;
        end
        ST_ENTER: begin
          clock_now   <= clock_now + CNT_W'(1);
          comp_depth  <= comp_depth + CNT_W'(1);
          frame_depth <= frame_depth + CNT_W'(1);
          cur_v       <= pend;
          cur_low     <= clock_now + CNT_W'(1);
          cur_stamp   <= clock_now + CNT_W'(1);
        end
        ST_HEAD: cur_cursor <= head_rd;
        ST_STEP: pop_count <= '0;
        ST_EDGE: begin
          cur_cursor <= edge_rd.link;
          pend       <= edge_rd.dest;
        end
        ST_CHECK: begin
          if (stamp_rd != '0 && on_rd && stamp_rd < cur_low) cur_low <= stamp_rd;
        end
        ST_POP_RD: begin
          if (comp_depth == '0) begin
            total_cnt <= total_cnt + CNT_W'(1);
            if (pop_count == 2'd2) big_cnt <= big_cnt + CNT_W'(1);
          end
        end
        ST_POP_CHK: begin
          comp_depth <= cdepth_m1;
          if (pop_count != 2'd2) pop_count <= pop_count + 2'd1;
          if (comp_rd == cur_v) begin
            total_cnt <= total_cnt + CNT_W'(1);
            if (pop_count != 2'd0) big_cnt <= big_cnt + CNT_W'(1);
          end
        end
        ST_FRAME_RD: begin
          child_low   <= cur_low;
          frame_depth <= fdepth_m1;
          if (frame_depth == CNT_W'(1)) root <= root_inc;
          sweep <= '0;
        end
        ST_FRAME_LD: begin
          cur_v      <= frame_rd.vertex;
          cur_cursor <= frame_rd.cursor;
        end
        ST_FRAME_LOW: begin
          cur_stamp <= stamp_rd;
          cur_low   <= (child_low < low_rd) ? child_low : low_rd;
        end
        ST_DONE: begin
          if (out_load) begin
            out_data  <= '{nontrivial_components: big_cnt,
                           total_components: total_cnt,
                           edges_dropped: overflow_mark};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/scc_checker.sv
// Port-level checker for the component counter, bound to the top level.
module scc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input scc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input scc_pkg::out_item_t out_data
);
  import scc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.nontrivial_components <= out_data.total_components)
    else $error("nontrivial count exceeds total");

  a_add_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.opcode == OP_ADD && !out_valid |=> !out_valid)
    else $error("edge transaction produced a result");

  a_reset_busy: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input accepted during reset sweep");

endmodule

bind strongly_connected_component_count_core scc_checker u_scc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
